/* rtl/dual_tone_generator_unit_assert.svh */
// Assertion macros shared by the dual tone generator RTL.
// The macros assume a clock clk_i and an active-low reset rst_ni in scope.
`ifndef DUAL_TONE_GENERATOR_UNIT_ASSERT_SVH
`define DUAL_TONE_GENERATOR_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DTG_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dtg assertion failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define DTG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dtg assertion failed: next-cycle implication");

`endif

/* rtl/dtg_pkg.sv */
// Package for the dual tone generator: sizes, register indexes, the command
// type between front and back, and the quarter-wave sine ROM contents.
`timescale 1ns / 1ps
`default_nettype none

package dtg_pkg;

  localparam int PhaseBits     = 32;
  localparam int TableAddrBits = 10;
  localparam int CountBits     = 24;

  localparam int TblSize    = 1 << TableAddrBits;
  localparam int WaveBits   = TableAddrBits + 2;
  localparam int CfgDataW   = 32;
  localparam int CfgIdxW    = 2;
  localparam int StepW      = 32;
  localparam int SamplesW   = 24;
  localparam int RomW       = 15;
  localparam int SampleW    = 16;

  localparam int CmdDepth   = 4;
  localparam int CmdPtrW    = $clog2(CmdDepth);
  localparam int CmdCntW    = $clog2(CmdDepth + 1);
  localparam int OutDepth   = 4;
  localparam int OutPtrW    = $clog2(OutDepth);
  localparam int OutCntW    = $clog2(OutDepth + 1);

  localparam logic [RomW-1:0] FullScale = 15'd32767;

  typedef enum logic [CfgIdxW-1:0] {
    RegLowStep  = 2'd0,
    RegHighStep = 2'd1,
    RegSamples  = 2'd2
  } cfg_reg_e;

  // One sample to be synthesized: the wave address of each tone and the burst flag.
  typedef struct packed {
    logic [WaveBits-1:0] low_addr;
    logic [WaveBits-1:0] high_addr;
    logic                last;
  } dtg_cmd_t;

  typedef logic [RomW-1:0] sine_rom_t [TblSize];

  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
  localparam logic [63:0] OneQ30    = 64'd1 << 30;

  // Denominators (2n)(2n+1) of the odd Taylor terms.
  function automatic logic [63:0] taylor_den(input int n);
    logic [63:0] den;
    case (n)
      1:       den = 64'd6;
      2:       den = 64'd20;
      3:       den = 64'd42;
      4:       den = 64'd72;
      5:       den = 64'd110;
      6:       den = 64'd156;
      7:       den = 64'd210;
      default: den = 64'd272;
    endcase
    return den;
  endfunction

  // Unsigned quotient by shift and subtract, evaluated only while the ROM
  // contents are built.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // sin(x) for x in [0, pi/2], Q30 fixed point in and out.
  function automatic logic [63:0] sin_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] res;
    x2   = (x * x) >> 30;
    term = x;
    pos  = x;
    neg  = '0;
    for (int n = 1; n <= 8; n++) begin
      term = udiv64((term * x2) >> 30, taylor_den(n));
      if ((n % 2) == 1) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    if (neg >= pos) begin
      res = '0;
    end else begin
      res = pos - neg;
      if (res > OneQ30) begin
        res = OneQ30;
      end
    end
    return res;
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] v;
    for (int k = 0; k < TblSize; k++) begin
      x = (64'(k) * HalfPiQ30) >> TableAddrBits;
      v = (sin_q30(x) * 64'd32767 + (OneQ30 >> 1)) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      rom[k] = v[RomW-1:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SineRom = build_sine_rom();

endpackage

`default_nettype wire

/* rtl/dtg_front.sv */
// Front end: configuration registers, tick acceptance, burst counting and
// phase accumulation. Emits one command per produced sample. Uses dtg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtg_front import dtg_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                push,
  output      logic                full,
  input  wire logic                restart_i,
  output      logic                cmd_push_o,
  output      dtg_cmd_t            cmd_o,
  input  wire logic                cmd_full_i
);

  logic [PhaseBits-1:0] low_step_q, high_step_q;
  logic [CountBits-1:0] limit_q;
  logic [PhaseBits-1:0] low_phase_q, low_phase_d;
  logic [PhaseBits-1:0] high_phase_q, high_phase_d;
  logic [CountBits-1:0] index_q, index_d;

  logic                 accept;
  logic                 produce;
  logic [PhaseBits-1:0] low_cur, high_cur;
  logic [CountBits-1:0] index_cur;
  logic [CountBits:0]   index_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_step_q  <= '0;
      high_step_q <= '0;
      limit_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        RegLowStep:  low_step_q  <= PhaseBits'(cfg_wdata_i[StepW-1:0]);
        RegHighStep: high_step_q <= PhaseBits'(cfg_wdata_i[StepW-1:0]);
        RegSamples:  limit_q     <= CountBits'(cfg_wdata_i[SamplesW-1:0]);
        default: ;
      endcase
    end
  end

  assign full   = cmd_full_i;
  assign accept = push && !cmd_full_i;

  // A restart clears the burst before this tick is evaluated.
  always_comb begin
    low_cur    = restart_i ? '0 : low_phase_q;
    high_cur   = restart_i ? '0 : high_phase_q;
    index_cur  = restart_i ? '0 : index_q;
    index_next = {1'b0, index_cur} + (CountBits+1)'(1);
    produce    = accept && (index_cur < limit_q);

    low_phase_d  = low_phase_q;
    high_phase_d = high_phase_q;
    index_d      = index_q;
    if (produce) begin
      low_phase_d  = low_cur + low_step_q;
      high_phase_d = high_cur + high_step_q;
      index_d      = index_next[CountBits-1:0];
    end else if (accept) begin
      low_phase_d  = low_cur;
      high_phase_d = high_cur;
      index_d      = index_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_phase_q  <= '0;
      high_phase_q <= '0;
      index_q      <= '0;
    end else begin
      low_phase_q  <= low_phase_d;
      high_phase_q <= high_phase_d;
      index_q      <= index_d;
    end
  end

  assign cmd_push_o        = produce;
  assign cmd_o.low_addr    = low_cur[PhaseBits-1 -: WaveBits];
  assign cmd_o.high_addr   = high_cur[PhaseBits-1 -: WaveBits];
  assign cmd_o.last        = (index_next == {1'b0, limit_q});

endmodule

`default_nettype wire

/* rtl/dtg_cmd_queue.sv */
// Short command queue that decouples the front end from the synthesis back end.
// Depth from dtg_pkg; entries are dtg_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module dtg_cmd_queue import dtg_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     wr_i,
  input  wire dtg_cmd_t wdata_i,
  output      logic     full_o,
  input  wire logic     rd_i,
  output      dtg_cmd_t rdata_o,
  output      logic     empty_o
);

  dtg_cmd_t           mem_q [CmdDepth];
  logic [CmdPtrW-1:0] wptr_q, rptr_q;
  logic [CmdCntW-1:0] cnt_q;
  logic               do_wr, do_rd;

  assign full_o  = (cnt_q == CmdCntW'(CmdDepth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= wptr_q + CmdPtrW'(1);
      end
      if (do_rd) begin
        rptr_q <= rptr_q + CmdPtrW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CmdCntW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CmdCntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/dtg_back.sv */
// Back end: two-port sine ROM read, quadrant folding, half-amplitude sum and
// the result queue. Uses dtg_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "dual_tone_generator_unit_assert.svh"

module dtg_back import dtg_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dtg_cmd_t           cmd_i,
  input  wire logic               cmd_empty_i,
  output      logic               cmd_pop_o,
  output      logic               empty,
  input  wire logic               pop,
  output      logic signed [SampleW-1:0] sample_o,
  output      logic               last_o
);

  // Folded ROM addressing of one tone.
  function automatic logic [TableAddrBits-1:0] fold_addr(input logic [WaveBits-1:0] a);
    logic [TableAddrBits-1:0] k;
    k = a[TableAddrBits-1:0];
    return a[TableAddrBits] ? (~k) + TableAddrBits'(1) : k;
  endfunction

  function automatic logic is_peak(input logic [WaveBits-1:0] a);
    return a[TableAddrBits] && (a[TableAddrBits-1:0] == '0);
  endfunction

  function automatic logic signed [SampleW-1:0] half_tone(input logic [RomW-1:0] rom,
                                                          input logic peak,
                                                          input logic neg);
    logic [RomW-1:0]           v;
    logic signed [SampleW-1:0] h;
    v = peak ? FullScale : rom;
    h = $signed({2'b00, v[RomW-1:1]});
    return neg ? -h : h;
  endfunction

  logic               s1_valid_q;
  logic [RomW-1:0]    low_rom_q, high_rom_q;
  logic               low_peak_q, high_peak_q, low_neg_q, high_neg_q, last_q;
  logic [OutCntW-1:0] out_cnt_q;
  logic [OutCntW:0]   committed;

  // Issue only when the result queue has room for everything in flight.
  assign committed = {1'b0, out_cnt_q} + (OutCntW+1)'(s1_valid_q);
  assign cmd_pop_o = !cmd_empty_i && (committed < (OutCntW+1)'(OutDepth));

  always_ff @(posedge clk_i) begin
    low_rom_q   <= SineRom[fold_addr(cmd_i.low_addr)];
    high_rom_q  <= SineRom[fold_addr(cmd_i.high_addr)];
    low_peak_q  <= is_peak(cmd_i.low_addr);
    high_peak_q <= is_peak(cmd_i.high_addr);
    low_neg_q   <= cmd_i.low_addr[WaveBits-1];
    high_neg_q  <= cmd_i.high_addr[WaveBits-1];
    last_q      <= cmd_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= cmd_pop_o;
    end
  end

  logic signed [SampleW-1:0] sum;
  assign sum = half_tone(low_rom_q, low_peak_q, low_neg_q) +
               half_tone(high_rom_q, high_peak_q, high_neg_q);

  // Result queue.
  logic [SampleW-1:0] out_sample_q [OutDepth];
  logic               out_last_q   [OutDepth];
  logic [OutPtrW-1:0] out_wptr_q, out_rptr_q;
  logic               out_rd;

  assign empty    = (out_cnt_q == '0);
  assign out_rd   = pop && !empty;
  assign sample_o = $signed(out_sample_q[out_rptr_q]);
  assign last_o   = out_last_q[out_rptr_q];

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      out_sample_q[out_wptr_q] <= sum;
      out_last_q[out_wptr_q]   <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_wptr_q <= '0;
      out_rptr_q <= '0;
      out_cnt_q  <= '0;
    end else begin
      if (s1_valid_q) begin
        out_wptr_q <= out_wptr_q + OutPtrW'(1);
      end
      if (out_rd) begin
        out_rptr_q <= out_rptr_q + OutPtrW'(1);
      end
      if (s1_valid_q && !out_rd) begin
        out_cnt_q <= out_cnt_q + OutCntW'(1);
      end else if (out_rd && !s1_valid_q) begin
        out_cnt_q <= out_cnt_q - OutCntW'(1);
      end
    end
  end

  `DTG_ASSERT_IMPLY(a_out_no_overflow, s1_valid_q, out_cnt_q < OutCntW'(OutDepth))
  `DTG_ASSERT_IMPLY(a_out_cnt_bound, 1'b1, out_cnt_q <= OutCntW'(OutDepth))
  `DTG_ASSERT_NEXT(a_issue_lands, cmd_pop_o, s1_valid_q)

endmodule

`default_nettype wire

/* rtl/dual_tone_generator_unit.sv */
// Channel   | Direction | Handshake              | Payload
// config    | in        | cfg_we_i               | cfg_idx_i, cfg_wdata_i
// tick      | in        | push / full            | restart_i
// sample    | out       | empty / pop            | sample_o, last_o
//
// One tick per cycle is accepted while full is low; a produced sample reaches
// the result ports through the command queue, the registered ROM read and
// the result queue. The dual-read sine ROM reads both tones of a sample at once;
// room in the result queue sets the pace of the back end.
// Reset clears phases, count, registers and both queues; no clearing pass.
// A stalled pop backs up into the command queue, which then raises full.
// Depends on dtg_pkg, dtg_front, dtg_cmd_queue and dtg_back.
`timescale 1ns / 1ps
`default_nettype none

module dual_tone_generator_unit import dtg_pkg::*; (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [CfgIdxW-1:0]        cfg_idx_i,
  input  wire logic [CfgDataW-1:0]       cfg_wdata_i,
  input  wire logic                      push,
  output      logic                      full,
  input  wire logic                      restart_i,
  output      logic                      empty,
  input  wire logic                      pop,
  output      logic signed [SampleW-1:0] sample_o,
  output      logic                      last_o
);

  dtg_cmd_t cmd_wdata, cmd_rdata;
  logic     cmd_push, cmd_full, cmd_pop, cmd_empty;

  dtg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .restart_i   (restart_i),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_wdata),
    .cmd_full_i  (cmd_full)
  );

  dtg_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cmd_push),
    .wdata_i (cmd_wdata),
    .full_o  (cmd_full),
    .rd_i    (cmd_pop),
    .rdata_o (cmd_rdata),
    .empty_o (cmd_empty)
  );

  dtg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_rdata),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .sample_o    (sample_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire
